FILE: design/ffha_pkg.sv
`default_nettype none
package ffha_pkg;

    localparam int HEAP_BYTES   = 4194304;
    localparam int HEADER_BYTES = 12;
    localparam int MAX_BLOCKS   = 64;
    localparam int SPLIT_SLACK  = 8;

    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = IDX_W + 1;
    localparam int OFF_W  = $clog2(HEAP_BYTES);
    localparam int SIZE_W = 24;

    typedef struct packed {
        logic             used;
        logic [OFF_W-1:0] size;
        logic [OFF_W-1:0] off;
    } entry_t;

    localparam entry_t RESET_ENTRY = '{
        used: 1'b0,
        size: OFF_W'(HEAP_BYTES - HEADER_BYTES),
        off:  '0
    };

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
    } tbl_req_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_IGNORED = 2'd2
    } status_t;

    typedef enum logic {
        FN_ALLOC = 1'b0,
        FN_FREE  = 1'b1
    } func_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SHU_RD,
        S_SHU_WR,
        S_INS_WR,
        S_ALC_WR,
        S_MRG_RD,
        S_MRG_CHK,
        S_SHD_RD,
        S_SHD_WR,
        S_FRE_WR,
        S_DONE
    } state_t;

endpackage
`default_nettype wire

FILE: design/ffha_table.sv
`default_nettype none
module ffha_table (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire ffha_pkg::tbl_req_t req,
    output ffha_pkg::entry_t       rd_data
);

    ffha_pkg::entry_t mem [ffha_pkg::MAX_BLOCKS];
    ffha_pkg::entry_t rd_data_reg;
    logic             e0_init_reg;
    logic             fresh_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
            fresh_reg   <= (req.rd_addr == '0) && e0_init_reg;
        end
    end

    // entry 0 reads as the whole free heap until first written
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e0_init_reg <= 1'b1;
        end else if (req.wr_en && req.wr_addr == '0) begin
            e0_init_reg <= 1'b0;
        end
    end

    assign rd_data = fresh_reg ? ffha_pkg::RESET_ENTRY : rd_data_reg;

endmodule
`default_nettype wire

FILE: design/ffha_ctrl.sv
`default_nettype none
module ffha_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [31:0]          heap_base,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 in_func,
    input  wire logic [22:0]          in_req_size,
    input  wire logic [31:0]          in_release_addr,
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output logic [31:0]               res_grant,
    output ffha_pkg::status_t         res_status,
    output ffha_pkg::tbl_req_t        tbl_req,
    input  wire ffha_pkg::entry_t     tbl_rd
);

    localparam int IW = ffha_pkg::IDX_W;
    localparam int CW = ffha_pkg::CNT_W;
    localparam int OW = ffha_pkg::OFF_W;
    localparam int SW = ffha_pkg::SIZE_W;

    ffha_pkg::state_t  state_reg, state_next;
    ffha_pkg::func_t   func_reg, func_next;
    logic [SW-1:0]     sz_reg, sz_next;
    logic [OW-1:0]     tgt_reg, tgt_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [IW-1:0]     hit_reg, hit_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     src_reg, src_next;
    logic [CW-1:0]     mrg_reg, mrg_next;
    logic [OW-1:0]     cur_off_reg, cur_off_next;
    logic [OW-1:0]     cur_size_reg, cur_size_next;
    logic [OW-1:0]     nb_off_reg, nb_off_next;
    logic [OW-1:0]     nb_size_reg, nb_size_next;
    logic [31:0]       grant_reg, grant_next;
    ffha_pkg::status_t status_reg, status_next;

    logic [32:0] addr_w, base_w, dist_w, off_w;
    logic        free_ok;
    logic        fits, split, match;
    logic [SW:0] need_w;
    logic        accept;

    assign accept = in_valid && in_ready;

    always_comb begin
        addr_w  = {1'b0, in_release_addr};
        base_w  = {1'b0, heap_base};
        dist_w  = addr_w - base_w;
        off_w   = dist_w - 33'(ffha_pkg::HEADER_BYTES);
        free_ok = (in_release_addr != '0) && (addr_w >= base_w)
                  && (dist_w < 33'(ffha_pkg::HEAP_BYTES))
                  && (dist_w >= 33'(ffha_pkg::HEADER_BYTES));
        need_w  = {1'b0, sz_reg} + (SW+1)'(ffha_pkg::HEADER_BYTES + ffha_pkg::SPLIT_SLACK);
        fits    = !tbl_rd.used && ({{(SW-OW){1'b0}}, tbl_rd.size} >= sz_reg);
        split   = ({{(SW+1-OW){1'b0}}, tbl_rd.size} > need_w)
                  && (cnt_reg < CW'(ffha_pkg::MAX_BLOCKS));
        match   = tbl_rd.off == tgt_reg;
    end

    // next state and datapath
    always_comb begin
        state_next    = state_reg;
        func_next     = func_reg;
        sz_next       = sz_reg;
        tgt_next      = tgt_reg;
        idx_next      = idx_reg;
        hit_next      = hit_reg;
        cnt_next      = cnt_reg;
        src_next      = src_reg;
        mrg_next      = mrg_reg;
        cur_off_next  = cur_off_reg;
        cur_size_next = cur_size_reg;
        nb_off_next   = nb_off_reg;
        nb_size_next  = nb_size_reg;
        grant_next    = grant_reg;
        status_next   = status_reg;
        unique case (state_reg)
            ffha_pkg::S_IDLE: begin
                if (accept) begin
                    func_next  = ffha_pkg::func_t'(in_func);
                    sz_next    = ({1'b0, in_req_size} + SW'(3)) & ~SW'(3);
                    tgt_next   = off_w[OW-1:0];
                    idx_next   = '0;
                    grant_next = '0;
                    if (in_func == ffha_pkg::FN_FREE && !free_ok) begin
                        status_next = ffha_pkg::ST_IGNORED;
                        state_next  = ffha_pkg::S_DONE;
                    end else begin
                        state_next = ffha_pkg::S_SCAN_RD;
                    end
                end
            end
            ffha_pkg::S_SCAN_RD: begin
                if (idx_reg == cnt_reg) begin
                    status_next = (func_reg == ffha_pkg::FN_ALLOC) ?
                                  ffha_pkg::ST_NOFIT : ffha_pkg::ST_IGNORED;
                    state_next  = ffha_pkg::S_DONE;
                end else begin
                    state_next = ffha_pkg::S_SCAN_CHK;
                end
            end
            ffha_pkg::S_SCAN_CHK: begin
                hit_next      = idx_reg[IW-1:0];
                cur_off_next  = tbl_rd.off;
                cur_size_next = tbl_rd.size;
                nb_off_next   = tbl_rd.off + OW'(ffha_pkg::HEADER_BYTES) + sz_reg[OW-1:0];
                nb_size_next  = tbl_rd.size - sz_reg[OW-1:0]
                                - OW'(ffha_pkg::HEADER_BYTES);
                src_next      = cnt_reg;
                mrg_next      = '0;
                idx_next      = idx_reg + CW'(1);
                if (func_reg == ffha_pkg::FN_ALLOC) begin
                    if (fits) begin
                        if (split) begin
                            cur_size_next = sz_reg[OW-1:0];
                            state_next    = ffha_pkg::S_SHU_RD;
                        end else begin
                            state_next = ffha_pkg::S_ALC_WR;
                        end
                    end else begin
                        state_next = ffha_pkg::S_SCAN_RD;
                    end
                end else begin
                    state_next = match ? ffha_pkg::S_MRG_RD : ffha_pkg::S_SCAN_RD;
                end
            end
            ffha_pkg::S_SHU_RD: begin
                if (src_reg == {1'b0, hit_reg} + CW'(1)) begin
                    state_next = ffha_pkg::S_INS_WR;
                end else begin
                    state_next = ffha_pkg::S_SHU_WR;
                end
            end
            ffha_pkg::S_SHU_WR: begin
                src_next   = src_reg - CW'(1);
                state_next = ffha_pkg::S_SHU_RD;
            end
            ffha_pkg::S_INS_WR: begin
                cnt_next   = cnt_reg + CW'(1);
                state_next = ffha_pkg::S_ALC_WR;
            end
            ffha_pkg::S_ALC_WR: begin
                grant_next  = heap_base + {{(32-OW){1'b0}}, cur_off_reg}
                              + 32'(ffha_pkg::HEADER_BYTES);
                status_next = ffha_pkg::ST_DONE;
                state_next  = ffha_pkg::S_DONE;
            end
            ffha_pkg::S_MRG_RD: begin
                src_next   = idx_reg;
                state_next = (idx_reg == cnt_reg) ? ffha_pkg::S_SHD_RD : ffha_pkg::S_MRG_CHK;
            end
            ffha_pkg::S_MRG_CHK: begin
                src_next = idx_reg;
                if (!tbl_rd.used) begin
                    cur_size_next = cur_size_reg + OW'(ffha_pkg::HEADER_BYTES) + tbl_rd.size;
                    mrg_next      = mrg_reg + CW'(1);
                    idx_next      = idx_reg + CW'(1);
                    state_next    = ffha_pkg::S_MRG_RD;
                end else begin
                    state_next = ffha_pkg::S_SHD_RD;
                end
            end
            ffha_pkg::S_SHD_RD: begin
                if (mrg_reg == '0 || src_reg == cnt_reg) begin
                    state_next = ffha_pkg::S_FRE_WR;
                end else begin
                    state_next = ffha_pkg::S_SHD_WR;
                end
            end
            ffha_pkg::S_SHD_WR: begin
                src_next   = src_reg + CW'(1);
                state_next = ffha_pkg::S_SHD_RD;
            end
            ffha_pkg::S_FRE_WR: begin
                cnt_next    = cnt_reg - mrg_reg;
                status_next = ffha_pkg::ST_DONE;
                state_next  = ffha_pkg::S_DONE;
            end
            ffha_pkg::S_DONE: begin
                if (res_ready) begin
                    state_next = ffha_pkg::S_IDLE;
                end
            end
            default: state_next = ffha_pkg::S_IDLE;
        endcase
    end

    // outputs and table port
    always_comb begin
        in_ready        = 1'b0;
        res_valid       = 1'b0;
        tbl_req.rd_en   = 1'b0;
        tbl_req.rd_addr = '0;
        tbl_req.wr_en   = 1'b0;
        tbl_req.wr_addr = '0;
        tbl_req.wr_data = '0;
        unique case (state_reg)
            ffha_pkg::S_IDLE: in_ready = 1'b1;
            ffha_pkg::S_SCAN_RD: begin
                tbl_req.rd_en   = idx_reg != cnt_reg;
                tbl_req.rd_addr = idx_reg[IW-1:0];
            end
            ffha_pkg::S_SHU_RD: begin
                tbl_req.rd_en   = src_reg != {1'b0, hit_reg} + CW'(1);
                tbl_req.rd_addr = IW'(src_reg - CW'(1));
            end
            ffha_pkg::S_SHU_WR: begin
                tbl_req.wr_en   = 1'b1;
                tbl_req.wr_addr = src_reg[IW-1:0];
                tbl_req.wr_data = tbl_rd;
            end
            ffha_pkg::S_INS_WR: begin
                tbl_req.wr_en   = 1'b1;
                tbl_req.wr_addr = hit_reg + IW'(1);
                tbl_req.wr_data = '{used: 1'b0, size: nb_size_reg, off: nb_off_reg};
            end
            ffha_pkg::S_ALC_WR: begin
                tbl_req.wr_en   = 1'b1;
                tbl_req.wr_addr = hit_reg;
                tbl_req.wr_data = '{used: 1'b1, size: cur_size_reg, off: cur_off_reg};
            end
            ffha_pkg::S_MRG_RD: begin
                tbl_req.rd_en   = idx_reg != cnt_reg;
                tbl_req.rd_addr = idx_reg[IW-1:0];
            end
            ffha_pkg::S_SHD_RD: begin
                tbl_req.rd_en   = !(mrg_reg == '0 || src_reg == cnt_reg);
                tbl_req.rd_addr = src_reg[IW-1:0];
            end
            ffha_pkg::S_SHD_WR: begin
                tbl_req.wr_en   = 1'b1;
                tbl_req.wr_addr = IW'(src_reg - mrg_reg);
                tbl_req.wr_data = tbl_rd;
            end
            ffha_pkg::S_FRE_WR: begin
                tbl_req.wr_en   = 1'b1;
                tbl_req.wr_addr = hit_reg;
                tbl_req.wr_data = '{used: 1'b0, size: cur_size_reg, off: cur_off_reg};
            end
            ffha_pkg::S_DONE: res_valid = 1'b1;
            default: ;
        endcase
    end

    assign res_grant  = grant_reg;
    assign res_status = status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ffha_pkg::S_IDLE;
            cnt_reg   <= CW'(1);
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg     <= func_next;
        sz_reg       <= sz_next;
        tgt_reg      <= tgt_next;
        idx_reg      <= idx_next;
        hit_reg      <= hit_next;
        src_reg      <= src_next;
        mrg_reg      <= mrg_next;
        cur_off_reg  <= cur_off_next;
        cur_size_reg <= cur_size_next;
        nb_off_reg   <= nb_off_next;
        nb_size_reg  <= nb_size_next;
        grant_reg    <= grant_next;
        status_reg   <= status_next;
    end

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != '0 && cnt_reg <= CW'(ffha_pkg::MAX_BLOCKS))
        else $error("block count out of range");

    a_wr_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        tbl_req.wr_en |-> {1'b0, tbl_req.wr_addr} <= cnt_reg)
        else $error("table write beyond block count");

    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(tbl_req.rd_en && tbl_req.wr_en))
        else $error("table read and write in one cycle");

    a_result_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_ready) |=> in_ready)
        else $error("controller not idle after result transfer");

endmodule
`default_nettype wire

FILE: design/first_fit_heap_allocator.sv
// Channel  | Handshake          | Payload
// s_       | s_valid / s_ready  | s_func, s_req_size, s_release_addr
// m_       | m_valid / m_ready  | m_grant_addr, m_status
// cfg_     | cfg_wr_en          | cfg_wr_data (heap_base)
//
// One item at a time; the block table sits in a single-port-read, single-port-write RAM.
// A scan visits the entries in order; a split shifts the tail up one entry at a time;
// a free merges and shifts the tail down, one entry at a time.
// Reset is synchronous; entry 0 reads as the whole free heap until first written.
// Results sit in an output register, so a new item is taken while m_valid waits on m_ready.
`default_nettype none
module first_fit_heap_allocator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_func,
    input  wire logic [22:0] s_req_size,
    input  wire logic [31:0] s_release_addr,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_grant_addr,
    output logic [1:0]       m_status
);

    logic [31:0]        heap_base_reg;
    logic               m_valid_reg, m_valid_next;
    logic [31:0]        grant_reg;
    ffha_pkg::status_t  status_reg;

    logic               res_valid, res_ready;
    logic [31:0]        res_grant;
    ffha_pkg::status_t  res_status;
    ffha_pkg::tbl_req_t tbl_req;
    ffha_pkg::entry_t   tbl_rd;

    ffha_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (tbl_req),
        .rd_data (tbl_rd)
    );

    ffha_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .heap_base       (heap_base_reg),
        .in_valid        (s_valid),
        .in_ready        (s_ready),
        .in_func         (s_func),
        .in_req_size     (s_req_size),
        .in_release_addr (s_release_addr),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .res_grant       (res_grant),
        .res_status      (res_status),
        .tbl_req         (tbl_req),
        .tbl_rd          (tbl_rd)
    );

    // load when the output register is empty or being drained
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_base_reg <= 32'h0040_0000;
            m_valid_reg   <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                heap_base_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            grant_reg  <= res_grant;
            status_reg <= res_status;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_grant_addr = grant_reg;
    assign m_status     = status_reg;

endmodule
`default_nettype wire

FILE: test/first_fit_heap_allocator_tb.sv
`default_nettype none
module first_fit_heap_allocator_tb;

    typedef struct {
        ffha_pkg::func_t func;
        logic [22:0]     req_size;
        logic [31:0]     release_addr;
    } heap_req_t;

    typedef struct {
        logic [31:0]       grant_addr;
        ffha_pkg::status_t status;
    } heap_resp_t;

    typedef struct {
        logic [31:0] off;
        logic [31:0] size;
        logic        used;
    } blk_t;

    localparam int LIMIT_CYCLES = 2000000;
    localparam int DRAIN_CYCLES = 4 * ffha_pkg::MAX_BLOCKS + 40;
    localparam int HOLD_CYCLES  = 3000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_func = 1'b0;
    logic [22:0] s_req_size = '0;
    logic [31:0] s_release_addr = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_grant_addr;
    logic [1:0]  m_status;

    first_fit_heap_allocator dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_func(s_func),
        .s_req_size(s_req_size), .s_release_addr(s_release_addr),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_grant_addr(m_grant_addr), .m_status(m_status)
    );

    always #1 aclk = ~aclk;

    // allocator shadow
    blk_t        blocks[ffha_pkg::MAX_BLOCKS];
    int          nblocks;
    logic [31:0] heap_base;
    logic [31:0] live_addrs[$];

    heap_req_t  pending_reqs[$];
    heap_resp_t expected_resps[$];
    int         mismatches = 0;
    int         n_accepted = 0;
    int         n_results = 0;
    int         n_nofit = 0;
    int         n_ignored = 0;
    int         n_grants = 0;
    int         cycles = 0;
    bit         hold_off = 1'b0;
    bit         hold_done = 1'b0;
    logic       s_ready_q = 1'b0;

    function automatic void reset_heap();
        foreach (blocks[k]) blocks[k] = '{0, 0, 1'b0};
        blocks[0].size = ffha_pkg::HEAP_BYTES - ffha_pkg::HEADER_BYTES;
        nblocks = 1;
        heap_base = 32'h0040_0000;
    endfunction

    function automatic heap_resp_t predict_alloc(logic [22:0] req);
        logic [31:0] sz;
        heap_resp_t r;
        blk_t nb;
        sz = (32'(req) + 32'd3) & ~32'd3;
        for (int i = 0; i < nblocks; i++) begin
            if (!blocks[i].used && blocks[i].size >= sz) begin
                if (64'(blocks[i].size) > 64'(sz) + ffha_pkg::HEADER_BYTES
                        + ffha_pkg::SPLIT_SLACK && nblocks < ffha_pkg::MAX_BLOCKS) begin
                    nb.off = blocks[i].off + ffha_pkg::HEADER_BYTES + sz;
                    nb.size = blocks[i].size - sz - ffha_pkg::HEADER_BYTES;
                    nb.used = 1'b0;
                    blocks[i].size = sz;
                    for (int k = nblocks; k > i + 1; k--) blocks[k] = blocks[k-1];
                    blocks[i+1] = nb;
                    nblocks++;
                end
                blocks[i].used = 1'b1;
                r.grant_addr = heap_base + blocks[i].off + ffha_pkg::HEADER_BYTES;
                r.status = ffha_pkg::ST_DONE;
                return r;
            end
        end
        r.grant_addr = '0;
        r.status = ffha_pkg::ST_NOFIT;
        return r;
    endfunction

    function automatic heap_resp_t predict_free(logic [31:0] addr);
        logic [63:0] base, off;
        heap_resp_t r;
        base = 64'(heap_base);
        r.grant_addr = '0;
        r.status = ffha_pkg::ST_IGNORED;
        if (addr == 0 || 64'(addr) < base || 64'(addr) >= base + ffha_pkg::HEAP_BYTES)
            return r;
        if (64'(addr) < base + ffha_pkg::HEADER_BYTES) return r;
        off = 64'(addr) - ffha_pkg::HEADER_BYTES - base;
        for (int i = 0; i < nblocks; i++) begin
            if (64'(blocks[i].off) == off) begin
                blocks[i].used = 1'b0;
                while (i + 1 < nblocks && !blocks[i+1].used) begin
                    blocks[i].size += ffha_pkg::HEADER_BYTES + blocks[i+1].size;
                    for (int k = i + 1; k + 1 < nblocks; k++) blocks[k] = blocks[k+1];
                    nblocks--;
                end
                r.status = ffha_pkg::ST_DONE;
                return r;
            end
        end
        return r;
    endfunction

    function automatic logic [22:0] rand_size();
        case ($urandom_range(0, 9))
            0:       return 23'($urandom_range(0, 8));
            1:       return 23'($urandom_range(0, 23'h7fffff));
            2:       return 23'($urandom_range(262144, 1048576));
            default: return 23'($urandom_range(1, 20000));
        endcase
    endfunction

    function automatic logic [31:0] rand_free_addr();
        int j;
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return heap_base
                      + 32'($urandom_range(0, ffha_pkg::HEAP_BYTES / 4 - 1) * 4);
            2: return 32'($urandom_range(0, 1)) ?
                      heap_base + ffha_pkg::HEADER_BYTES - 4 : '0;
            default: begin
                if (live_addrs.size() == 0) return heap_base + ffha_pkg::HEADER_BYTES;
                j = $urandom_range(0, live_addrs.size() - 1);
                rand_free_addr = live_addrs[j];
                live_addrs.delete(j);
            end
        endcase
    endfunction

    // predict at queue time: the block handles items strictly in order
    task automatic push_req(ffha_pkg::func_t f, logic [22:0] sz, logic [31:0] addr);
        heap_req_t q;
        heap_resp_t r;
        q.func = f;
        q.req_size = sz;
        q.release_addr = addr;
        r = (f == ffha_pkg::FN_ALLOC) ? predict_alloc(sz) : predict_free(addr);
        if (f == ffha_pkg::FN_ALLOC && r.status == ffha_pkg::ST_DONE)
            live_addrs.push_back(r.grant_addr);
        pending_reqs.push_back(q);
        expected_resps.push_back(r);
    endtask

    task automatic write_base(logic [31:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        heap_base = value;
        live_addrs.delete();
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || expected_resps.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // driver
    int send_gap = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready_q) begin
                void'(pending_reqs.pop_front());
                send_gap = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 60)
                         : ($urandom_range(0, 2) == 0 ? $urandom_range(0, 3) : 0);
            end
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                s_valid <= 1'b1;
                s_func <= pending_reqs[0].func;
                s_req_size <= pending_reqs[0].req_size;
                s_release_addr <= pending_reqs[0].release_addr;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // registered transfer flag for the driver
    always @(posedge aclk) begin
        s_ready_q <= s_valid && s_ready;
        if (s_valid && s_ready) n_accepted++;
    end

    // receiver stall pattern; count out the long hold-off here
    int recv_gap = 0;
    int hold_cnt = 0;
    always @(negedge aclk) begin
        if (hold_off && !hold_done) begin
            m_ready <= 1'b0;
            hold_cnt++;
            if (hold_cnt >= HOLD_CYCLES) hold_done = 1'b1;
        end else if (recv_gap > 0) begin
            recv_gap--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                recv_gap = ($urandom_range(0, 20) == 0) ? $urandom_range(10, 80)
                                                        : $urandom_range(1, 3);
        end
    end

    // monitor
    always @(posedge aclk) begin
        heap_resp_t e;
        cycles++;
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (expected_resps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: grant=%h status=%0d",
                             m_grant_addr, m_status);
            end else begin
                e = expected_resps.pop_front();
                if (m_status == ffha_pkg::ST_NOFIT) n_nofit++;
                if (m_status == ffha_pkg::ST_IGNORED) n_ignored++;
                if (m_status == ffha_pkg::ST_DONE && m_grant_addr != 0) n_grants++;
                if (m_grant_addr !== e.grant_addr || m_status !== e.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch #%0d: grant exp %h got %h, status exp %0d got %0d",
                                 n_results, e.grant_addr, m_grant_addr, e.status, m_status);
                end
            end
        end
        if (cycles >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 55) push_req(ffha_pkg::FN_ALLOC, rand_size(), '0);
            else push_req(ffha_pkg::FN_FREE, rand_size(), rand_free_addr());
            // refill room now and then so the table churns
            if ($urandom_range(0, 199) == 0)
                while (live_addrs.size() != 0)
                    push_req(ffha_pkg::FN_FREE, '0, rand_free_addr());
        end
    endtask

    initial begin
        reset_heap();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: zero size, rounding, max size, nulls, out of heap, unmatched
        push_req(ffha_pkg::FN_ALLOC, 23'd0, '0);
        push_req(ffha_pkg::FN_ALLOC, 23'd1, '0);
        push_req(ffha_pkg::FN_ALLOC, 23'd5, '0);
        push_req(ffha_pkg::FN_ALLOC, 23'h7fffff, '0);
        push_req(ffha_pkg::FN_ALLOC,
                 23'(ffha_pkg::HEAP_BYTES - ffha_pkg::HEADER_BYTES), '0);
        push_req(ffha_pkg::FN_FREE, '0, '0);
        push_req(ffha_pkg::FN_FREE, '0, heap_base - 1);
        push_req(ffha_pkg::FN_FREE, '0, heap_base + ffha_pkg::HEAP_BYTES);
        push_req(ffha_pkg::FN_FREE, '0, heap_base + 4);
        push_req(ffha_pkg::FN_FREE, '0, heap_base + 16);
        push_req(ffha_pkg::FN_FREE, '0, 32'hffff_ffff);
        push_req(ffha_pkg::FN_FREE, '0, heap_base + 12 + 8);
        push_req(ffha_pkg::FN_FREE, '0, heap_base + 12);
        push_req(ffha_pkg::FN_FREE, '0, heap_base + 12);
        push_req(ffha_pkg::FN_ALLOC, 23'd100, '0);
        // fill the table so no split can happen
        for (int i = 0; i < ffha_pkg::MAX_BLOCKS + 2; i++)
            push_req(ffha_pkg::FN_ALLOC, 23'd16, '0);
        push_req(ffha_pkg::FN_ALLOC, 23'd8, '0);
        wait_idle();

        // long receiver hold-off while the sender keeps offering
        hold_off = 1'b1;
        random_phase(40);
        wait (hold_done);
        hold_off = 1'b0;
        random_phase(500);
        wait_idle();

        write_base(32'h0000_0000);
        random_phase(350);
        wait_idle();
        write_base(32'hffc0_0000);
        random_phase(350);
        wait_idle();
        write_base(32'hfff0_0000);
        push_req(ffha_pkg::FN_FREE, '0, 32'hffff_fff0);
        random_phase(200);
        wait_idle();
        write_base($urandom() & 32'hffff_fffc);
        random_phase(280);
        wait_idle();

        $display("covered %0d requests: %0d grants, %0d no-fit, %0d ignored frees",
                 n_accepted, n_grants, n_nofit, n_ignored);
        $display("heap base moved through zero, top of address space and random values");
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: files.f
design/ffha_pkg.sv
design/ffha_table.sv
design/ffha_ctrl.sv
design/first_fit_heap_allocator.sv
test/first_fit_heap_allocator_tb.sv
